/* design/osps_pkg.sv */
`timescale 1ns / 1ps

package osps_pkg;

    // Number of cells folded by one first-level reduction group.
    localparam int GROUP_SIZE = 16;

    // Request opcodes.
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_DONE = 2'd0;
    localparam logic [1:0] STATUS_DUP  = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_RED,
        ST_FIN
    } t_state;

    // Comparison flags that a cell holds against the request key.
    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } t_cell_flags;

endpackage

/* design/osps_cell.sv */
`timescale 1ns / 1ps

module osps_cell import osps_pkg::*; #(
    parameter int KEY_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_cmp_en,
    input  logic                i_occ,
    input  logic [KEY_BITS-1:0] i_query_key,
    input  logic                i_shift_en,
    input  logic                i_prev_lt,
    input  logic [KEY_BITS-1:0] i_prev_key,
    output logic [KEY_BITS-1:0] o_key,
    output t_cell_flags         o_flags
);

    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] n_key;
    t_cell_flags         r_flags;
    t_cell_flags         n_flags;

    // Compare the held key against the broadcast request key.
    always_comb begin
        n_flags.lt = i_occ && (r_key < i_query_key);
        n_flags.eq = i_occ && (r_key == i_query_key);
        n_flags.gt = i_occ && (r_key > i_query_key);
    end

    // On an insertion, smaller keys stay, the first cell without a smaller key
    // takes the new key and every later cell takes its left neighbour's key.
    always_comb begin
        n_key = r_key;
        if (i_shift_en && !r_flags.lt) begin
            if (i_prev_lt) begin
                n_key = i_query_key;
            end else begin
                n_key = i_prev_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        if (i_cmp_en) begin
            r_flags <= n_flags;
        end
    end

    assign o_key   = r_key;
    assign o_flags = r_flags;

endmodule

/* design/osps_group.sv */
`timescale 1ns / 1ps

module osps_group import osps_pkg::*; #(
    parameter int KEY_BITS = 16
) (
    input  logic                i_clk,
    input  logic [KEY_BITS-1:0] i_key [GROUP_SIZE],
    input  logic                i_sel_p [GROUP_SIZE],
    input  logic                i_sel_s [GROUP_SIZE],
    input  logic                i_eq [GROUP_SIZE],
    output logic [KEY_BITS-1:0] o_pred,
    output logic [KEY_BITS-1:0] o_succ,
    output logic                o_succ_any,
    output logic                o_hit
);

    logic [KEY_BITS-1:0] n_pred;
    logic [KEY_BITS-1:0] n_succ;
    logic                n_succ_any;
    logic                n_hit;

    // At most one cell of the whole row is selected, so a masked OR picks it.
    always_comb begin
        n_pred     = '0;
        n_succ     = '0;
        n_succ_any = 1'b0;
        n_hit      = 1'b0;
        for (int i = 0; i < GROUP_SIZE; i++) begin
            n_pred     = n_pred | (i_key[i] & {KEY_BITS{i_sel_p[i]}});
            n_succ     = n_succ | (i_key[i] & {KEY_BITS{i_sel_s[i]}});
            n_succ_any = n_succ_any | i_sel_s[i];
            n_hit      = n_hit | i_eq[i];
        end
    end

    always_ff @(posedge i_clk) begin
        o_pred     <= n_pred;
        o_succ     <= n_succ;
        o_succ_any <= n_succ_any;
        o_hit      <= n_hit;
    end

endmodule

/* design/ordered_set_pred_succ.sv */
`timescale 1ns / 1ps

// Ordered key set with membership, predecessor and successor lookup.
// Input channel (i_valid / o_ready) carries a request: i_mode clears the set,
// adds i_key, or queries i_key. Output channel (o_valid / i_ready) returns one
// result per request: a status, the membership flag and the strict
// predecessor and successor, each with a valid flag and zero when absent.
// The keys sit sorted in a row of CAPACITY cells; each cell compares its key
// with the request key, and an insertion shifts larger keys one cell along.
// A request runs in steps from acceptance to its result: the cells compare
// and register their flags, groups of 16 cells fold into registers, then the
// groups fold and the result commits; one request is in flight at a time.
// The result sits in an output register; if the receiver stalls, the next
// request still runs up to its commit cycle and then waits there until the
// register is free. Reset empties the set and drops any pending result; no
// clearing pass is needed, as the key count alone marks occupied cells.
module ordered_set_pred_succ import osps_pkg::*; #(
    parameter int KEY_BITS = 16,
    parameter int CAPACITY = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_key,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic        o_is_member,
    output logic        o_pred_valid,
    output logic [15:0] o_pred_key,
    output logic        o_succ_valid,
    output logic [15:0] o_succ_key
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int NGRP = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int NPAD = NGRP * GROUP_SIZE;

    t_state              r_state;
    t_state              n_state;
    logic [1:0]          r_mode;
    logic [KEY_BITS-1:0] r_key;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;

    logic                r_out_valid;
    logic [1:0]          r_status;
    logic                r_is_member;
    logic                r_pred_valid;
    logic [15:0]         r_pred_key;
    logic                r_succ_valid;
    logic [15:0]         r_succ_key;

    logic                w_accept;
    logic                w_cmp_en;
    logic                w_commit;
    logic                w_shift_en;

    logic [KEY_BITS-1:0] w_key [CAPACITY];
    t_cell_flags         w_flags [CAPACITY];

    logic [KEY_BITS-1:0] w_pad_key [NPAD];
    logic                w_pad_sel_p [NPAD];
    logic                w_pad_sel_s [NPAD];
    logic                w_pad_eq [NPAD];

    logic [KEY_BITS-1:0] w_grp_pred [NGRP];
    logic [KEY_BITS-1:0] w_grp_succ [NGRP];
    logic                w_grp_succ_any [NGRP];
    logic                w_grp_hit [NGRP];

    logic [KEY_BITS-1:0] w_pred;
    logic [KEY_BITS-1:0] w_succ;
    logic                w_succ_any;
    logic                w_hit;
    logic                w_full;

    // Sequencer: request in, compare, group fold, final fold and commit.
    always_comb begin
        n_state  = r_state;
        o_ready  = 1'b0;
        w_cmp_en = 1'b0;
        w_commit = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = i_rst_n;
                if (i_valid) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                w_cmp_en = 1'b1;
                n_state  = ST_RED;
            end
            ST_RED: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!r_out_valid || i_ready) begin
                    w_commit = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Latch the request.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_mode;
            r_key  <= KEY_BITS'(i_key);
        end
    end

    // Row of key cells.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                c_prev_lt;
        logic [KEY_BITS-1:0] c_prev_key;
        logic                c_occ;

        if (i == 0) begin : g_first
            assign c_prev_lt  = 1'b1;
            assign c_prev_key = '0;
        end else begin : g_rest
            assign c_prev_lt  = w_flags[i-1].lt;
            assign c_prev_key = w_key[i-1];
        end

        assign c_occ = CW'(i) < r_count;

        osps_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_cmp_en    (w_cmp_en),
            .i_occ       (c_occ),
            .i_query_key (r_key),
            .i_shift_en  (w_shift_en),
            .i_prev_lt   (c_prev_lt),
            .i_prev_key  (c_prev_key),
            .o_key       (w_key[i]),
            .o_flags     (w_flags[i])
        );
    end

    // Predecessor is the last smaller cell, successor the first larger one.
    for (genvar i = 0; i < NPAD; i++) begin : g_sel
        if (i >= CAPACITY) begin : g_pad
            assign w_pad_key[i]   = '0;
            assign w_pad_sel_p[i] = 1'b0;
            assign w_pad_sel_s[i] = 1'b0;
            assign w_pad_eq[i]    = 1'b0;
        end else begin : g_live
            logic c_next_lt;
            logic c_prev_gt;

            if (i + 1 < CAPACITY) begin : g_nxt
                assign c_next_lt = w_flags[i+1].lt;
            end else begin : g_last
                assign c_next_lt = 1'b0;
            end
            if (i > 0) begin : g_prv
                assign c_prev_gt = w_flags[i-1].gt;
            end else begin : g_head
                assign c_prev_gt = 1'b0;
            end

            assign w_pad_key[i]   = w_key[i];
            assign w_pad_sel_p[i] = w_flags[i].lt && !c_next_lt;
            assign w_pad_sel_s[i] = w_flags[i].gt && !c_prev_gt;
            assign w_pad_eq[i]    = w_flags[i].eq;
        end
    end

    // First fold level, registered.
    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        logic [KEY_BITS-1:0] c_key [GROUP_SIZE];
        logic                c_sel_p [GROUP_SIZE];
        logic                c_sel_s [GROUP_SIZE];
        logic                c_eq [GROUP_SIZE];

        // Gather the cells that belong to this group.
        for (genvar k = 0; k < GROUP_SIZE; k++) begin : g_tap
            assign c_key[k]   = w_pad_key[g*GROUP_SIZE + k];
            assign c_sel_p[k] = w_pad_sel_p[g*GROUP_SIZE + k];
            assign c_sel_s[k] = w_pad_sel_s[g*GROUP_SIZE + k];
            assign c_eq[k]    = w_pad_eq[g*GROUP_SIZE + k];
        end

        osps_group #(
            .KEY_BITS (KEY_BITS)
        ) u_group (
            .i_clk      (i_clk),
            .i_key      (c_key),
            .i_sel_p    (c_sel_p),
            .i_sel_s    (c_sel_s),
            .i_eq       (c_eq),
            .o_pred     (w_grp_pred[g]),
            .o_succ     (w_grp_succ[g]),
            .o_succ_any (w_grp_succ_any[g]),
            .o_hit      (w_grp_hit[g])
        );
    end

    // Second fold level over the group results.
    always_comb begin
        w_pred     = '0;
        w_succ     = '0;
        w_succ_any = 1'b0;
        w_hit      = 1'b0;
        for (int g = 0; g < NGRP; g++) begin
            w_pred     = w_pred | w_grp_pred[g];
            w_succ     = w_succ | w_grp_succ[g];
            w_succ_any = w_succ_any | w_grp_succ_any[g];
            w_hit      = w_hit | w_grp_hit[g];
        end
    end

    assign w_full     = r_count == CW'(CAPACITY);
    assign w_shift_en = w_commit && (r_mode == MODE_ADD) && !w_hit && !w_full;

    // Key count update.
    always_comb begin
        n_count = r_count;
        if (w_commit && (r_mode == MODE_CLEAR)) begin
            n_count = '0;
        end else if (w_shift_en) begin
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Output register holds the result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_status     <= STATUS_DONE;
            r_is_member  <= 1'b0;
            r_pred_valid <= 1'b0;
            r_pred_key   <= '0;
            r_succ_valid <= 1'b0;
            r_succ_key   <= '0;
            case (r_mode)
                MODE_CLEAR: begin
                    r_status <= STATUS_DONE;
                end
                MODE_ADD: begin
                    if (w_hit) begin
                        r_status <= STATUS_DUP;
                    end else if (w_full) begin
                        r_status <= STATUS_FULL;
                    end
                end
                MODE_QUERY: begin
                    r_is_member  <= w_hit;
                    r_pred_valid <= w_flags[0].lt;
                    r_pred_key   <= 16'(w_pred);
                    r_succ_valid <= w_succ_any;
                    r_succ_key   <= 16'(w_succ);
                end
                default: begin
                    r_status <= STATUS_DONE;
                end
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_is_member  = r_is_member;
    assign o_pred_valid = r_pred_valid;
    assign o_pred_key   = r_pred_key;
    assign o_succ_valid = r_succ_valid;
    assign o_succ_key   = r_succ_key;

endmodule

/* design/osps_checker.sv */
`timescale 1ns / 1ps

module osps_checker import osps_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic        o_is_member,
    input logic        o_pred_valid,
    input logic [15:0] o_pred_key,
    input logic        o_succ_valid,
    input logic [15:0] o_succ_key
);

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_pred_key)
            && $stable(o_succ_key))
        else $error("stalled result changed");

    // One request at a time: ready drops after an accepted request.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request accepted while another is in flight");

    // A missing neighbour reads as zero.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_pred_valid |-> o_pred_key == 16'd0 && (o_succ_valid || o_succ_key == 16'd0))
        else $error("absent neighbour key is not zero");

    // Non-zero status only comes from an add, which reports no lookup fields.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != STATUS_DONE |-> !o_is_member && !o_pred_valid && !o_succ_valid)
        else $error("add result carries lookup fields");

    // Predecessor lies strictly below successor.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pred_valid && o_succ_valid |-> o_pred_key < o_succ_key)
        else $error("predecessor not below successor");

endmodule

bind ordered_set_pred_succ osps_checker u_osps_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_status     (o_status),
    .o_is_member  (o_is_member),
    .o_pred_valid (o_pred_valid),
    .o_pred_key   (o_pred_key),
    .o_succ_valid (o_succ_valid),
    .o_succ_key   (o_succ_key)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench import osps_pkg::*;;

    localparam int          STORE_DEPTH  = 256;
    localparam int          RANDOM_ITEMS = 650;
    localparam int          HOLD_AT      = 140;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          TAIL_CYCLES  = 12;
    localparam logic [1:0]  MODE_UNUSED  = 2'd3;

    // One answer as it leaves the block, in port order.
    typedef struct packed {
        logic [1:0]  status;
        logic        is_member;
        logic        pred_valid;
        logic [15:0] pred_key;
        logic        succ_valid;
        logic [15:0] succ_key;
    } answer_t;

    // Mirror of the stored key set and the answers still owed by the block.
    class ordered_set_board;
        logic [15:0] set_keys[$];
        answer_t     pending_answers[$];
        int          n_errors;
        int          n_checked;
        int          n_hits;
        int          n_dups;
        int          n_full;
        int          peak_size;

        // Position of the first stored key that is not below k.
        function int first_not_below(logic [15:0] k);
            int lo;
            int hi;
            int mid;
            lo = 0;
            hi = set_keys.size();
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if (set_keys[mid] < k) begin
                    lo = mid + 1;
                end else begin
                    hi = mid;
                end
            end
            return lo;
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            n_errors++;
        endtask

        // Update the set for an accepted request and queue the answer it owes.
        function void apply_request(logic [1:0] mode, logic [15:0] key);
            answer_t ans;
            int      pos;
            int      after;
            bit      hit;
            ans = '0;
            case (mode)
                MODE_CLEAR: begin
                    set_keys.delete();
                end
                MODE_ADD: begin
                    pos = first_not_below(key);
                    if (pos < set_keys.size() && set_keys[pos] == key) begin
                        ans.status = STATUS_DUP;
                        n_dups++;
                    end else if (set_keys.size() >= STORE_DEPTH) begin
                        ans.status = STATUS_FULL;
                        n_full++;
                    end else begin
                        set_keys.insert(pos, key);
                    end
                end
                MODE_QUERY: begin
                    pos = first_not_below(key);
                    hit = (pos < set_keys.size()) && (set_keys[pos] == key);
                    ans.is_member = hit;
                    if (hit) begin
                        n_hits++;
                    end
                    if (pos > 0) begin
                        ans.pred_valid = 1'b1;
                        ans.pred_key   = set_keys[pos - 1];
                    end
                    // A member key is not its own successor.
                    after = hit ? pos + 1 : pos;
                    if (after < set_keys.size()) begin
                        ans.succ_valid = 1'b1;
                        ans.succ_key   = set_keys[after];
                    end
                end
                default: begin
                end
            endcase
            if (set_keys.size() > peak_size) begin
                peak_size = set_keys.size();
            end
            pending_answers.push_back(ans);
        endfunction

        // Compare one accepted answer against the oldest one owed.
        task check_answer(answer_t got);
            answer_t want;
            if (pending_answers.size() == 0) begin
                report("answer arrived with no request outstanding");
                return;
            end
            want = pending_answers.pop_front();
            n_checked++;
            if (got.status !== want.status)
                report($sformatf("status: got %0d, expected %0d", got.status, want.status));
            if (got.is_member !== want.is_member)
                report($sformatf("is_member: got %0b, expected %0b",
                                 got.is_member, want.is_member));
            if (got.pred_valid !== want.pred_valid)
                report($sformatf("pred_valid: got %0b, expected %0b",
                                 got.pred_valid, want.pred_valid));
            if (got.pred_key !== want.pred_key)
                report($sformatf("pred_key: got %04h, expected %04h",
                                 got.pred_key, want.pred_key));
            if (got.succ_valid !== want.succ_valid)
                report($sformatf("succ_valid: got %0b, expected %0b",
                                 got.succ_valid, want.succ_valid));
            if (got.succ_key !== want.succ_key)
                report($sformatf("succ_key: got %04h, expected %04h",
                                 got.succ_key, want.succ_key));
        endtask
    endclass

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [1:0]  i_mode  = MODE_CLEAR;
    logic [15:0] i_key   = 16'h0000;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_status;
    logic        o_is_member;
    logic        o_pred_valid;
    logic [15:0] o_pred_key;
    logic        o_succ_valid;
    logic [15:0] o_succ_key;

    ordered_set_board board = new();

    int   n_sent        = 0;
    int   n_random      = 0;
    int   send_idle_pct = 31;
    int   recv_idle_pct = 64;
    logic hold_ready    = 1'b0;

    ordered_set_pred_succ #(
        .KEY_BITS (16),
        .CAPACITY (STORE_DEPTH)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_key        (i_key),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_is_member  (o_is_member),
        .o_pred_valid (o_pred_valid),
        .o_pred_key   (o_pred_key),
        .o_succ_valid (o_succ_valid),
        .o_succ_key   (o_succ_key)
    );

    // Clock generation.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Present one request, with an optional idle gap first, and wait for it to be taken.
    task automatic send_request(input logic [1:0] mode, input logic [15:0] key);
        int gap;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 5);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode  <= mode;
        i_key   <= key;
        do @(posedge i_clk); while (!o_ready);
        board.apply_request(mode, key);
        n_sent++;
    endtask

    // Stop offering requests until every owed answer has been collected.
    task automatic wait_all_answers();
        i_valid <= 1'b0;
        while (board.pending_answers.size() != 0) @(posedge i_clk);
    endtask

    // Keys biased towards the extremes, stored keys and their neighbours.
    function automatic logic [15:0] pick_key();
        int          sz;
        logic [15:0] k;
        sz = board.set_keys.size();
        k  = 16'($urandom());
        case ($urandom_range(9))
            0: k = 16'h0000;
            1: k = 16'hFFFF;
            2, 3: if (sz > 0) k = board.set_keys[$urandom_range(sz - 1)];
            4: if (sz > 0) k = board.set_keys[$urandom_range(sz - 1)] + 16'd1;
            5: if (sz > 0) k = board.set_keys[$urandom_range(sz - 1)] - 16'd1;
            6: k = 16'h7F00 + 16'($urandom_range(511));
            default: begin
            end
        endcase
        return k;
    endfunction

    // Receiving side: collect answers and stall at random or during the hold-off.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                board.check_answer({o_status, o_is_member, o_pred_valid, o_pred_key,
                                    o_succ_valid, o_succ_key});
            end
            i_ready <= !hold_ready && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // One long receiver hold-off while requests keep coming, so the block backs up.
    initial begin
        wait (n_sent >= HOLD_AT);
        @(posedge i_clk);
        hold_ready <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_ready <= 1'b0;
    end

    // Overall time limit.
    initial begin
        #400000;
        $display("ordered_set_pred_succ test failed");
        $finish;
    end

    // Stimulus and final verdict.
    initial begin
        int  phase;
        int  len;
        int  r;
        int  j;
        bit  filled;
        phase  = 1;
        filled = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests: empty set, extremes, duplicates, unused mode, clear.
        send_request(MODE_QUERY, 16'h0000);
        send_request(MODE_ADD,   16'h0000);
        send_request(MODE_ADD,   16'hFFFF);
        send_request(MODE_ADD,   16'h0000);
        send_request(MODE_QUERY, 16'h0000);
        send_request(MODE_QUERY, 16'hFFFF);
        send_request(MODE_QUERY, 16'h8000);
        send_request(MODE_ADD,   16'h0001);
        send_request(MODE_ADD,   16'hFFFE);
        send_request(MODE_QUERY, 16'h0001);
        send_request(MODE_QUERY, 16'hFFFE);
        send_request(MODE_UNUSED, 16'hFFFF);
        send_request(MODE_UNUSED, 16'h1234);
        send_request(MODE_QUERY, 16'h0000);
        send_request(MODE_CLEAR, 16'hFFFF);
        send_request(MODE_QUERY, 16'hFFFF);
        send_request(MODE_ADD,   16'h8000);
        send_request(MODE_QUERY, 16'h7FFF);
        send_request(MODE_QUERY, 16'h8001);
        send_request(MODE_ADD,   16'h5555);
        send_request(MODE_ADD,   16'hAAAA);
        send_request(MODE_QUERY, 16'h8000);
        send_request(MODE_CLEAR, 16'h0000);

        // Random episodes: mostly a clear followed by adds and queries.
        while (n_random < RANDOM_ITEMS) begin
            if (phase == 1 && n_random >= RANDOM_ITEMS / 3) begin
                wait_all_answers();
                phase         = 2;
                send_idle_pct = 64;
                recv_idle_pct = 31;
            end else if (phase == 2 && n_random >= 2 * RANDOM_ITEMS / 3) begin
                phase         = 3;
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (!filled && n_random >= 60) begin
                // Fill the store to capacity, then hammer the full store.
                filled = 1'b1;
                send_request(MODE_CLEAR, 16'($urandom()));
                n_random++;
                while (board.set_keys.size() < STORE_DEPTH) begin
                    send_request(MODE_ADD, 16'($urandom()));
                    n_random++;
                end
                for (j = 0; j < 40; j++) begin
                    if ($urandom_range(1) == 0) begin
                        send_request(MODE_ADD, pick_key());
                    end else begin
                        send_request(MODE_QUERY, pick_key());
                    end
                    n_random++;
                end
            end else begin
                if ($urandom_range(3) != 0) begin
                    send_request(MODE_CLEAR, 16'($urandom()));
                    n_random++;
                end
                len = $urandom_range(8, 50);
                for (j = 0; j < len; j++) begin
                    r = $urandom_range(99);
                    if (r < 45) begin
                        send_request(MODE_ADD, pick_key());
                        n_random++;
                    end else if (r < 93) begin
                        send_request(MODE_QUERY, pick_key());
                        n_random++;
                    end else if (r < 97) begin
                        send_request(MODE_CLEAR, 16'($urandom()));
                        n_random++;
                    end else begin
                        send_request(MODE_UNUSED, 16'($urandom()));
                    end
                end
            end
        end

        // Drain, then keep watching for stray answers.
        wait_all_answers();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.pending_answers.size() != 0) begin
            board.report($sformatf("%0d answers never arrived", board.pending_answers.size()));
        end

        $display("Sent %0d requests and checked %0d answers: %0d member hits, %0d duplicate adds,",
                 n_sent, board.n_checked, board.n_hits, board.n_dups);
        $display("%0d adds refused by a full store, largest set %0d keys, one long receiver stall.",
                 board.n_full, board.peak_size);
        if (board.n_errors == 0) begin
            $display("ordered_set_pred_succ test passed");
        end else begin
            $display("ordered_set_pred_succ test failed");
        end
        $finish;
    end

endmodule

/* ordered_set_pred_succ.f */
design/osps_pkg.sv
design/osps_cell.sv
design/osps_group.sv
design/ordered_set_pred_succ.sv
design/osps_checker.sv
tb/testbench.sv
